FILE: rtl/mcd_pkg.sv
// ----------------------------------------------------------------------------
// mcd_pkg
// Control line positions, item types and helper functions for the
// microcode control word decoder.
// ----------------------------------------------------------------------------
package mcd_pkg;

  localparam int unsigned CW_W = 24;

  typedef logic [CW_W-1:0] cword_t;

  // control line bits of the logical (active-high) word
  localparam cword_t L_CI  = cword_t'(1) << 0;
  localparam cword_t L_CO  = cword_t'(1) << 1;
  localparam cword_t L_BO  = cword_t'(1) << 2;
  localparam cword_t L_BI  = cword_t'(1) << 3;
  localparam cword_t L_ALO = cword_t'(1) << 8;
  localparam cword_t L_ALI = cword_t'(1) << 9;
  localparam cword_t L_RI  = cword_t'(1) << 10;
  localparam cword_t L_RO  = cword_t'(1) << 11;
  localparam cword_t L_MD  = cword_t'(1) << 12;
  localparam cword_t L_MI  = cword_t'(1) << 13;
  localparam cword_t L_SPO = cword_t'(1) << 14;
  localparam cword_t L_SPI = cword_t'(1) << 15;
  localparam cword_t L_AO  = cword_t'(1) << 16;
  localparam cword_t L_AI  = cword_t'(1) << 17;
  localparam cword_t L_HLT = cword_t'(1) << 18;
  localparam cword_t L_PE  = cword_t'(1) << 19;
  localparam cword_t L_PO  = cword_t'(1) << 20;
  localparam cword_t L_PI  = cword_t'(1) << 21;
  localparam cword_t L_MSR = cword_t'(1) << 22;
  localparam cword_t L_II  = cword_t'(1) << 23;

  // all lines but the ALU code and PE are active low
  localparam cword_t LOW_ACTIVE_MASK = L_PI | L_PO | L_HLT | L_AI | L_AO | L_BI | L_BO |
                                       L_CI | L_CO | L_MI | L_RO | L_RI | L_ALO | L_ALI |
                                       L_SPO | L_SPI | L_MSR | L_II | L_MD;

  // opcode classes
  localparam logic [1:0] CLS_MOV = 2'd0;
  localparam logic [1:0] CLS_LOD = 2'd1;
  localparam logic [1:0] CLS_STO = 2'd2;
  localparam logic [1:0] CLS_ALU = 2'd3;

  // register / mode codes
  localparam logic [2:0] REG_A   = 3'd0;
  localparam logic [2:0] REG_B   = 3'd1;
  localparam logic [2:0] REG_C   = 3'd2;
  localparam logic [2:0] REG_D   = 3'd3;
  localparam logic [2:0] REG_SP  = 3'd4;
  localparam logic [2:0] REG_PC  = 3'd5;
  localparam logic [2:0] MODE_SI = 3'd6;
  localparam logic [2:0] MODE_IM = 3'd7;

  localparam logic [3:0] ALU_INC = 4'hA;
  localparam logic [3:0] ALU_DEC = 4'hB;

  localparam int unsigned IN_TDATA_W  = 16;

  typedef struct packed {
    logic       cond_flag;
    logic       carry_flag;
    logic [2:0] micro_step;
    logic [7:0] opcode;
  } mcd_item_t;

  function automatic cword_t alu_field(input logic [3:0] code);
    alu_field = cword_t'(code) << 4;
  endfunction

  function automatic cword_t drive_line(input logic [2:0] r);
    case (r)
      REG_A:   drive_line = L_AO;
      REG_B:   drive_line = L_BO;
      REG_C:   drive_line = L_CO;
      REG_D:   drive_line = L_SPO;
      REG_SP:  drive_line = L_SPO;
      REG_PC:  drive_line = L_PO;
      default: drive_line = '0;
    endcase
  endfunction

  function automatic cword_t load_line(input logic [2:0] r);
    case (r)
      REG_A:   load_line = L_AI;
      REG_B:   load_line = L_BI;
      REG_C:   load_line = L_CI;
      REG_D:   load_line = L_SPI;
      REG_SP:  load_line = L_SPI;
      REG_PC:  load_line = L_PI;
      default: load_line = '0;
    endcase
  endfunction

endpackage

FILE: rtl/mcd_decode.sv
// ----------------------------------------------------------------------------
// mcd_decode
// Combinational control store: maps opcode, step and flags to the
// 24-bit control word, with the active-low lines inverted.
// ----------------------------------------------------------------------------
module mcd_decode
  import mcd_pkg::*;
(
  input  mcd_item_t item,
  output cword_t    control_word
);

  logic [1:0] cls;
  logic [2:0] d;
  logic [2:0] s;
  logic [2:0] st;
  logic       take;
  cword_t     body;
  cword_t     w;

  assign cls = item.opcode[7:6];
  assign d   = item.opcode[5:3];
  assign s   = item.opcode[2:0];
  assign st  = item.micro_step;

  // body word for steps 2..7; zero falls back to HLT / MSR below
  always_comb begin
    body = '0;
    take = (s == REG_A) ? item.carry_flag : item.cond_flag;
    case (cls)
      CLS_MOV: begin
        if (d == MODE_IM && (s == REG_A || s == REG_B || s == REG_C || s == REG_SP)) begin
          // conditional jump
          if (!take) begin
            if (st == 3'd2) body = L_PE | L_MSR;
          end else if (st == 3'd2) begin
            body = L_PO | L_MI | L_PE;
          end else if (st == 3'd3) begin
            body = L_RO | L_PI | L_MSR;
          end
        end else if (item.opcode == 8'h00) begin
          if (st == 3'd2) body = L_MSR;
        end else if (d <= REG_PC && s <= REG_PC && s != d) begin
          if (st == 3'd2) body = drive_line(s) | load_line(d) | L_MSR;
        end else if (d <= REG_PC && s == MODE_IM) begin
          if (st == 3'd2) body = L_PO | L_MI | L_PE;
          else if (st == 3'd3) body = L_RO | load_line(d) | L_MSR;
        end
      end
      CLS_LOD: begin
        if (d <= REG_PC) begin
          if (s <= REG_PC) begin
            if (st == 3'd2) body = L_MI | drive_line(s);
            else if (st == 3'd3) body = L_MD | L_RO | load_line(d) | L_MSR;
          end else if (s == MODE_IM) begin
            if (st == 3'd2) body = L_PO | L_MI | L_PE;
            else if (st == 3'd3) body = L_RO | L_MI;
            else if (st == 3'd4) body = L_RO | L_MD | load_line(d) | L_MSR;
          end else begin
            if (st == 3'd2) body = L_SPO | L_ALI;
            else if (st == 3'd3) body = L_SPI | L_MI | alu_field(ALU_DEC) | L_ALO;
            else if (st == 3'd4) body = L_MD | L_RO | load_line(d) | L_MSR;
          end
        end
      end
      CLS_STO: begin
        if (s <= REG_PC) begin
          if (d <= REG_PC) begin
            if (st == 3'd2) body = L_MI | drive_line(d);
            else if (st == 3'd3) body = L_RI | L_MD | drive_line(s) | L_MSR;
          end else if (d == MODE_IM) begin
            if (st == 3'd2) body = L_MI | L_PE | L_PO;
            else if (st == 3'd3) body = L_RO | L_MI;
            else if (st == 3'd4) body = L_RI | L_MD | drive_line(s) | L_MSR;
          end else begin
            if (st == 3'd2) body = L_MI | L_ALI | L_SPO;
            else if (st == 3'd3) body = L_RI | L_MD | drive_line(s);
            else if (st == 3'd4) body = L_SPI | alu_field(ALU_INC) | L_ALO | L_MSR;
          end
        end
      end
      CLS_ALU: begin
        // bits 5-2 ALU code, bits 1-0 register
        if (st == 3'd2) begin
          body = drive_line({1'b0, item.opcode[1:0]}) | L_ALI;
        end else if (st == 3'd3) begin
          body = load_line({1'b0, item.opcode[1:0]}) | alu_field(item.opcode[5:2]) |
                 L_ALO | L_MSR;
        end
      end
      default: body = '0;
    endcase
  end

  always_comb begin
    if (st == 3'd0) begin
      w = L_MI | L_PO;
    end else if (st == 3'd1) begin
      w = L_RO | L_II | L_PE;
    end else if (body != '0) begin
      w = body;
    end else begin
      w = (st == 3'd2) ? L_HLT : L_MSR;
    end
  end

  assign control_word = w ^ LOW_ACTIVE_MASK;

endmodule

FILE: rtl/microcode_control_word_decoder.sv
// ----------------------------------------------------------------------------
// microcode_control_word_decoder
// Microcode control store for a small 8-bit CPU on a pair of streams.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream (in_*): one beat per lookup, in_tdata carries opcode,
//   micro-step, carry flag and condition flag. Output stream (out_*): one
//   beat per lookup with the 24-bit control word, active-low lines already
//   inverted.
//   Pipeline: the accepting edge loads the input register, and the output
//   register then loads through the decode logic once it is free; out_tvalid
//   rises when the output register is loaded.
//   Throughput: one beat per cycle, limited only by the receiver.
//   Stall: while out_tready is low the output register holds its beat; the
//   input register still takes one more beat, after which in_tready drops
//   until the output drains.
//   Reset: rst_n (synchronous, active low) empties both registers; no other
//   state exists, so decoding restarts cleanly on the next beat.
// ----------------------------------------------------------------------------
module microcode_control_word_decoder
  import mcd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // [7:0] opcode, [10:8] micro_step, [11] carry_flag, [12] cond_flag, [15:13] zero
  input  logic [IN_TDATA_W-1:0] in_tdata,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // [23:0] control_word
  output logic [CW_W-1:0]       out_tdata
);

  logic      s1_valid_r;
  logic      s1_valid_nxt;
  mcd_item_t s1_item_r;
  logic      out_valid_r;
  logic      out_valid_nxt;
  cword_t    out_word_r;
  cword_t    dec_word;
  logic      out_free;
  logic      s1_move;
  logic      in_take;

  assign out_free  = !out_valid_r || out_tready;
  assign s1_move   = s1_valid_r && out_free;
  assign in_tready = !s1_valid_r || out_free;
  assign in_take   = in_tvalid && in_tready;

  assign s1_valid_nxt  = in_take || (s1_valid_r && !out_free);
  assign out_valid_nxt = s1_move || (out_valid_r && !out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) s1_item_r <= mcd_item_t'(in_tdata[12:0]);
    if (s1_move) out_word_r <= dec_word;
  end

  mcd_decode u_decode (
    .item         (s1_item_r),
    .control_word (dec_word)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_word_r;

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid && !s1_valid_r)
    else $error("pipeline not empty after reset");

  a_stage_advance: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && out_free |=> out_valid_r)
    else $error("staged beat lost on its way to the output");

  a_ready_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> s1_valid_r && out_valid_r && !out_tready)
    else $error("input stalled with room in the pipeline");

  a_hold_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_tready |=> $stable(out_word_r) && s1_valid_r == $past(s1_valid_nxt))
    else $error("stalled output word changed");

endmodule

FILE: dv/microcode_control_word_decoder_test.sv
// ----------------------------------------------------------------------------
// microcode_control_word_decoder_test
// Streams control store lookups through the decoder and checks every output
// beat against a local predictor of the control word. Directed beats cover
// fetch, each opcode class and the jump and halt cases. Random instruction
// walks follow them. Both sides of the stream idle at random.
// ----------------------------------------------------------------------------
module microcode_control_word_decoder_test;
  import mcd_pkg::*;

  localparam int unsigned RANDOM_LOOKUPS = 1650;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned DRAIN_CYCLES   = 8;

  typedef struct {
    logic [7:0] op;
    logic [2:0] st;
    logic       cy;
    logic       fl;
    cword_t     word;
  } lookup_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_TDATA_W-1:0] in_tdata = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [CW_W-1:0]       out_tdata;

  lookup_t     pending_words[$];
  int unsigned mismatches = 0;
  int unsigned idle_cycles = 0;
  int unsigned rx_stall = 0;
  bit          tx_steady = 1'b0;
  bit          rx_steady = 1'b0;

  microcode_control_word_decoder dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // mostly short gaps, a few long ones
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [7:0] mk_op(input logic [1:0] cls, input logic [2:0] d,
                                       input logic [2:0] s);
    return {cls, d, s};
  endfunction

  function automatic cword_t src_enable(input logic [2:0] r);
    cword_t w;
    w = '0;
    case (r)
      REG_A:         w = L_AO;
      REG_B:         w = L_BO;
      REG_C:         w = L_CO;
      REG_D, REG_SP: w = L_SPO;
      REG_PC:        w = L_PO;
      default:       w = '0;
    endcase
    return w;
  endfunction

  function automatic cword_t dst_enable(input logic [2:0] r);
    cword_t w;
    w = '0;
    case (r)
      REG_A:         w = L_AI;
      REG_B:         w = L_BI;
      REG_C:         w = L_CI;
      REG_D, REG_SP: w = L_SPI;
      REG_PC:        w = L_PI;
      default:       w = '0;
    endcase
    return w;
  endfunction

  // control word as it leaves the store, active-low lines inverted
  function automatic cword_t control_word_for(input logic [7:0] op, input logic [2:0] st,
                                              input logic cy, input logic fl);
    logic [2:0] d;
    logic [2:0] s;
    logic       taken;
    cword_t     w;
    d = op[5:3];
    s = op[2:0];
    w = '0;
    if (st == 3'd0) begin
      w = L_MI | L_PO;
    end else if (st == 3'd1) begin
      w = L_RO | L_II | L_PE;
    end else begin
      case (op[7:6])
        CLS_MOV: begin
          if (d == MODE_IM && (s == REG_A || s == REG_B || s == REG_C || s == REG_SP)) begin
            taken = (s == REG_A) ? cy : fl;
            if (!taken) begin
              if (st == 3'd2) w = L_PE | L_MSR;
            end else if (st == 3'd2) begin
              w = L_PO | L_MI | L_PE;
            end else if (st == 3'd3) begin
              w = L_RO | L_PI | L_MSR;
            end
          end else if (op == 8'h00) begin
            if (st == 3'd2) w = L_MSR;
          end else if (d <= REG_PC && s <= REG_PC && s != d) begin
            if (st == 3'd2) w = src_enable(s) | dst_enable(d) | L_MSR;
          end else if (d <= REG_PC && s == MODE_IM) begin
            if (st == 3'd2) w = L_PO | L_MI | L_PE;
            else if (st == 3'd3) w = L_RO | dst_enable(d) | L_MSR;
          end
        end
        CLS_LOD: begin
          if (d <= REG_PC) begin
            if (s <= REG_PC) begin
              if (st == 3'd2) w = L_MI | src_enable(s);
              else if (st == 3'd3) w = L_MD | L_RO | dst_enable(d) | L_MSR;
            end else if (s == MODE_IM) begin
              if (st == 3'd2) w = L_PO | L_MI | L_PE;
              else if (st == 3'd3) w = L_RO | L_MI;
              else if (st == 3'd4) w = L_RO | L_MD | dst_enable(d) | L_MSR;
            end else begin
              // pop: SP goes through the ALU decrement
              if (st == 3'd2) w = L_SPO | L_ALI;
              else if (st == 3'd3) w = L_SPI | L_MI | {16'h0, ALU_DEC, 4'h0} | L_ALO;
              else if (st == 3'd4) w = L_MD | L_RO | dst_enable(d) | L_MSR;
            end
          end
        end
        CLS_STO: begin
          if (s <= REG_PC) begin
            if (d <= REG_PC) begin
              if (st == 3'd2) w = L_MI | src_enable(d);
              else if (st == 3'd3) w = L_RI | L_MD | src_enable(s) | L_MSR;
            end else if (d == MODE_IM) begin
              if (st == 3'd2) w = L_MI | L_PE | L_PO;
              else if (st == 3'd3) w = L_RO | L_MI;
              else if (st == 3'd4) w = L_RI | L_MD | src_enable(s) | L_MSR;
            end else begin
              // push: write through SP, then increment it
              if (st == 3'd2) w = L_MI | L_ALI | L_SPO;
              else if (st == 3'd3) w = L_RI | L_MD | src_enable(s);
              else if (st == 3'd4) w = L_SPI | {16'h0, ALU_INC, 4'h0} | L_ALO | L_MSR;
            end
          end
        end
        default: begin
          if (st == 3'd2) w = src_enable({1'b0, op[1:0]}) | L_ALI;
          else if (st == 3'd3)
            w = dst_enable({1'b0, op[1:0]}) | {16'h0, op[5:2], 4'h0} | L_ALO | L_MSR;
        end
      endcase
      if (w == '0) w = (st == 3'd2) ? L_HLT : L_MSR;
    end
    return w ^ LOW_ACTIVE_MASK;
  endfunction

  task automatic send_lookup(input logic [7:0] op, input logic [2:0] st, input logic cy,
                             input logic fl);
    int unsigned gap;
    gap = tx_steady ? 0 : idle_len();
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    // [7:0] opcode, [10:8] micro_step, [11] carry_flag, [12] cond_flag
    in_tdata  <= {3'b000, fl, cy, st, op};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic report_mismatch(input string what, input lookup_t exp_item, input cword_t got);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch (%s): op=%02h step=%0d cy=%b fl=%b expected %06h got %06h",
               what, exp_item.op, exp_item.st, exp_item.cy, exp_item.fl, exp_item.word, got);
  endtask

  // input side: predict on every accepted beat
  always @(posedge clk) begin : predict_beats
    lookup_t item;
    if (rst_n && in_tvalid && in_tready) begin
      item.op   = in_tdata[7:0];
      item.st   = in_tdata[10:8];
      item.cy   = in_tdata[11];
      item.fl   = in_tdata[12];
      item.word = control_word_for(item.op, item.st, item.cy, item.fl);
      pending_words.push_back(item);
    end
  end

  // output side: compare each beat with the oldest prediction
  always @(posedge clk) begin : check_beats
    lookup_t item;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_words.size() == 0) begin
        item = '{op: 8'h00, st: 3'd0, cy: 1'b0, fl: 1'b0, word: '0};
        report_mismatch("beat with nothing pending", item, out_tdata);
      end else begin
        item = pending_words.pop_front();
        if (out_tdata !== item.word) report_mismatch("control_word", item, out_tdata);
      end
    end
  end

  always @(posedge clk) begin : rx_backpressure
    if (rx_stall != 0) begin
      out_tready <= 1'b0;
      rx_stall   <= rx_stall - 1;
    end else begin
      out_tready <= 1'b1;
      if (!rx_steady && $urandom_range(0, 3) == 0) rx_stall <= idle_len();
    end
  end

  always @(posedge clk) begin : watchdog
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  task automatic test_fetch();
    send_lookup('1, 3'd0, 1'b0, 1'b0);
    send_lookup(8'h00, 3'd1, 1'b1, 1'b1);
  endtask

  task automatic test_moves();
    send_lookup(8'h00, 3'd2, 1'b0, 1'b0);                          // NOP
    send_lookup(mk_op(CLS_MOV, REG_PC, REG_PC), 3'd2, 1'b1, 1'b1); // halt
    send_lookup(mk_op(CLS_MOV, REG_B, REG_B), 3'd2, 1'b0, 1'b1);   // equal regs halt
    send_lookup(mk_op(CLS_MOV, REG_A, REG_B), 3'd2, 1'b0, 1'b0);
    send_lookup(mk_op(CLS_MOV, REG_C, MODE_IM), 3'd2, 1'b0, 1'b0);
    send_lookup(mk_op(CLS_MOV, REG_C, MODE_IM), 3'd3, 1'b1, 1'b0);
  endtask

  task automatic test_memory_ops();
    send_lookup(mk_op(CLS_LOD, REG_A, REG_B), 3'd3, 1'b0, 1'b0);
    send_lookup(mk_op(CLS_LOD, REG_B, MODE_IM), 3'd4, 1'b0, 1'b0);
    send_lookup(mk_op(CLS_LOD, REG_C, MODE_SI), 3'd3, 1'b1, 1'b1);
    send_lookup(mk_op(CLS_STO, REG_C, REG_A), 3'd3, 1'b0, 1'b0);
    send_lookup(mk_op(CLS_STO, MODE_IM, REG_A), 3'd4, 1'b0, 1'b0);
    send_lookup(mk_op(CLS_STO, MODE_SI, REG_D), 3'd4, 1'b0, 1'b0);
  endtask

  task automatic test_alu_ops();
    send_lookup({CLS_ALU, ALU_DEC, 2'd0}, 3'd2, 1'b0, 1'b0);
    send_lookup('1, 3'd3, 1'b1, 1'b1);
  endtask

  task automatic test_jumps();
    send_lookup(mk_op(CLS_MOV, MODE_IM, REG_A), 3'd2, 1'b0, 1'b1);  // carry, not taken
    send_lookup(mk_op(CLS_MOV, MODE_IM, REG_A), 3'd2, 1'b1, 1'b0);  // carry, taken
    send_lookup(mk_op(CLS_MOV, MODE_IM, REG_A), 3'd3, 1'b1, 1'b0);
    send_lookup(mk_op(CLS_MOV, MODE_IM, REG_SP), 3'd2, 1'b1, 1'b0); // flag, not taken
    send_lookup(mk_op(CLS_MOV, MODE_IM, REG_SP), 3'd3, 1'b0, 1'b1);
    send_lookup(mk_op(CLS_MOV, MODE_IM, REG_B), 3'd2, 1'b0, 1'b1);
    send_lookup(mk_op(CLS_MOV, MODE_IM, REG_C), 3'd4, 1'b0, 1'b1);  // past the last step
  endtask

  task automatic test_undefined();
    send_lookup(mk_op(CLS_MOV, MODE_IM, MODE_IM), 3'd2, 1'b1, 1'b1);
    send_lookup(mk_op(CLS_LOD, MODE_IM, MODE_IM), 3'd7, 1'b0, 1'b0);
  endtask

  // mostly whole instructions walked step by step, some scattered lookups
  task automatic test_random_lookups();
    int unsigned n;
    int unsigned next_phase;
    int unsigned last_step;
    logic [7:0]  op;
    logic        cy;
    logic        fl;
    n = 0;
    next_phase = 0;
    while (n < RANDOM_LOOKUPS) begin
      if (n >= next_phase) begin
        tx_steady  = ($urandom_range(0, 4) == 0);
        rx_steady  = ($urandom_range(0, 4) == 0);
        next_phase = n + 150;
      end
      if ($urandom_range(0, 9) < 7) begin
        if ($urandom_range(0, 4) == 0)
          op = mk_op(CLS_MOV, MODE_IM, ($urandom_range(0, 3) == 3) ? REG_SP
                                                                  : 3'($urandom_range(0, 2)));
        else
          op = 8'($urandom);
        cy = 1'($urandom);
        fl = 1'($urandom);
        last_step = $urandom_range(2, 7);
        for (int unsigned st = 0; st <= last_step; st++) begin
          if ($urandom_range(0, 4) == 0) begin
            cy = 1'($urandom);
            fl = 1'($urandom);
          end
          send_lookup(op, 3'(st), cy, fl);
          n++;
        end
      end else begin
        send_lookup(8'($urandom), 3'($urandom), 1'($urandom), 1'($urandom));
        n++;
      end
    end
    tx_steady = 1'b0;
    rx_steady = 1'b0;
  endtask

  initial begin
    rst_n <= 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    test_fetch();
    test_moves();
    test_memory_ops();
    test_alu_ops();
    test_jumps();
    test_undefined();
    test_random_lookups();

    in_tvalid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
